@@ src/crr_pkg.sv @@
// Shared types and constants for the completion result ring.
// No dependencies; every other file of the block uses this package.
package crr_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int MAX_PAYLOAD_DEF = 512;

	localparam int REQ_W    = 3;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 32;
	localparam int LEN_IN_W = 16;
	localparam int BYTE_W   = 8;
	localparam int SLOT_W   = 4;
	localparam int OFF_W    = 9;
	localparam int LEN_OUT_W = 10;

	localparam logic [REQ_W-1:0] REQ_STORE   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PAYLOAD = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FIND    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

	typedef enum logic [2:0] {
		OP_STORE,
		OP_PAYLOAD,
		OP_FIND,
		OP_REMOVE,
		OP_READ,
		OP_NONE
	} op_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		op_t                  op;
		logic [HANDLE_W-1:0]  handle;
		logic [STATUS_W-1:0]  status;
		logic [LEN_IN_W-1:0]  len;
		logic [BYTE_W-1:0]    pbyte;
		logic [SLOT_W-1:0]    slot;
		logic                 slot_ok;
		logic [OFF_W-1:0]     offset;
		logic                 off_ok;
	} cmd_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

@@ src/crr_front.sv @@
// Front end: classifies incoming requests and holds them in a two-entry queue.
// Depends on crr_pkg.
module crr_front #(
	parameter int DEPTH       = crr_pkg::DEPTH_DEF,
	parameter int MAX_PAYLOAD = crr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [crr_pkg::REQ_W-1:0]     req_type,
	input  logic [crr_pkg::HANDLE_W-1:0]  handle,
	input  logic [crr_pkg::STATUS_W-1:0]  status_in,
	input  logic [crr_pkg::LEN_IN_W-1:0]  response_length,
	input  logic [crr_pkg::BYTE_W-1:0]    payload_byte,
	input  logic [crr_pkg::SLOT_W-1:0]    slot_index,
	input  logic [crr_pkg::OFF_W-1:0]     byte_offset,
	input  logic                          pop,
	output crr_pkg::qhead_t               qhead
);
	import crr_pkg::*;

	cmd_t       cmd_new;
	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	always_comb begin
		cmd_new.handle  = handle;
		cmd_new.status  = status_in;
		cmd_new.len     = (32'(response_length) > MAX_PAYLOAD) ?
			LEN_IN_W'(MAX_PAYLOAD) : response_length;
		cmd_new.pbyte   = payload_byte;
		cmd_new.slot    = slot_index;
		cmd_new.slot_ok = 32'(slot_index) < DEPTH;
		cmd_new.offset  = byte_offset;
		cmd_new.off_ok  = 32'(byte_offset) < MAX_PAYLOAD;
		case (req_type)
			REQ_STORE:   cmd_new.op = OP_STORE;
			REQ_PAYLOAD: cmd_new.op = OP_PAYLOAD;
			REQ_FIND:    cmd_new.op = OP_FIND;
			REQ_REMOVE:  cmd_new.op = OP_REMOVE;
			REQ_READ:    cmd_new.op = OP_READ;
			default:     cmd_new.op = OP_NONE;
		endcase
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign qhead.valid = (count_q != 2'd0);
	assign qhead.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

@@ src/crr_back.sv @@
// Back end: ring pointers, header and payload memories, handle search and
// the result register. Depends on crr_pkg.
module crr_back #(
	parameter int DEPTH       = crr_pkg::DEPTH_DEF,
	parameter int MAX_PAYLOAD = crr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  crr_pkg::qhead_t                qhead,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           stored_clean,
	output logic                           found,
	output logic [crr_pkg::SLOT_W-1:0]     found_slot,
	output logic [crr_pkg::STATUS_W-1:0]   entry_status,
	output logic [crr_pkg::LEN_OUT_W-1:0]  entry_length,
	output logic [crr_pkg::BYTE_W-1:0]     byte_out
);
	import crr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = $clog2(DEPTH * MAX_PAYLOAD);
	localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_RD_WAIT} state_t;

	state_t                 state_q;
	logic [PW-1:0]          head_q, tail_q, fill_slot_q, scan_q;
	logic [LW-1:0]          fill_off_q, fill_len_q;
	logic [HANDLE_W-1:0]    key_q;
	logic                   out_valid_q;
	logic                   clean_q, found_q;
	logic [SLOT_W-1:0]      fslot_q;
	logic [STATUS_W-1:0]    fsts_q;
	logic [LEN_OUT_W-1:0]   flen_q;
	logic [BYTE_W-1:0]      bout_q;

	logic [HANDLE_W-1:0]    hdl_mem [DEPTH];
	logic [STATUS_W-1:0]    sts_mem [DEPTH];
	logic [LW-1:0]          len_mem [DEPTH];
	logic [BYTE_W-1:0]      pay_mem [DEPTH * MAX_PAYLOAD];
	logic [HANDLE_W-1:0]    hdl_rd_q;
	logic [STATUS_W-1:0]    sts_rd_q;
	logic [LW-1:0]          len_rd_q;
	logic [BYTE_W-1:0]      pay_rd_q;

	cmd_t                   cmd;
	logic                   issue, hdr_we, hdr_re, pay_we, pay_re;
	logic [PW-1:0]          head_nxt, tail_nxt, slot_pw;
	logic [AW-1:0]          pay_waddr, pay_raddr;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == LastSlot) ? '0 : p + PW'(1);
	endfunction

	assign cmd      = qhead.cmd;
	assign issue    = (state_q == S_IDLE) && qhead.valid && !out_valid_q;
	assign pop      = issue;
	assign head_nxt = ring_next(head_q);
	assign tail_nxt = ring_next(tail_q);
	assign slot_pw  = PW'(cmd.slot);
	assign hdr_we   = issue && (cmd.op == OP_STORE);
	assign pay_we   = issue && (cmd.op == OP_PAYLOAD) && (fill_off_q < fill_len_q);
	assign pay_re   = issue && (cmd.op == OP_READ) && cmd.slot_ok && cmd.off_ok;
	assign hdr_re   = (state_q == S_SCAN_RD) && (scan_q != head_q);
	assign pay_waddr = AW'(fill_slot_q) * AW'(MAX_PAYLOAD) + AW'(fill_off_q);
	assign pay_raddr = AW'(slot_pw) * AW'(MAX_PAYLOAD) + AW'(cmd.offset);

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdl_mem[head_q] <= cmd.handle;
			sts_mem[head_q] <= cmd.status;
			len_mem[head_q] <= LW'(cmd.len);
		end
		if (hdr_re) begin
			hdl_rd_q <= hdl_mem[scan_q];
			sts_rd_q <= sts_mem[scan_q];
			len_rd_q <= len_mem[scan_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_waddr] <= cmd.pbyte;
		end
		if (pay_re) begin
			pay_rd_q <= pay_mem[pay_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_slot_q <= '0;
			fill_off_q  <= '0;
			fill_len_q  <= '0;
			scan_q      <= '0;
			key_q       <= '0;
			out_valid_q <= 1'b0;
			clean_q     <= 1'b0;
			found_q     <= 1'b0;
			fslot_q     <= '0;
			fsts_q      <= '0;
			flen_q      <= '0;
			bout_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (issue) begin
						// A full ring drops its oldest entry first.
						clean_q <= (cmd.op == OP_STORE) && (head_nxt != tail_q);
						found_q <= 1'b0;
						fslot_q <= '0;
						fsts_q  <= '0;
						flen_q  <= '0;
						bout_q  <= '0;
						case (cmd.op)
							OP_STORE: begin
								if (head_nxt == tail_q) begin
									tail_q <= tail_nxt;
								end
								fill_slot_q <= head_q;
								fill_off_q  <= '0;
								fill_len_q  <= LW'(cmd.len);
								head_q      <= head_nxt;
								out_valid_q <= 1'b1;
							end
							OP_PAYLOAD: begin
								if (pay_we) begin
									fill_off_q <= fill_off_q + LW'(1);
								end
								out_valid_q <= 1'b1;
							end
							OP_FIND: begin
								scan_q  <= tail_q;
								key_q   <= cmd.handle;
								state_q <= S_SCAN_RD;
							end
							OP_REMOVE: begin
								if (cmd.slot_ok && slot_pw == tail_q && tail_q != head_q) begin
									tail_q <= tail_nxt;
								end
								out_valid_q <= 1'b1;
							end
							OP_READ: begin
								if (pay_re) begin
									state_q <= S_RD_WAIT;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					if (scan_q == head_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (hdl_rd_q == key_q) begin
						found_q     <= 1'b1;
						fslot_q     <= SLOT_W'(scan_q);
						fsts_q      <= sts_rd_q;
						flen_q      <= LEN_OUT_W'(len_rd_q);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						scan_q  <= ring_next(scan_q);
						state_q <= S_SCAN_RD;
					end
				end
				S_RD_WAIT: begin
					bout_q      <= pay_rd_q;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign stored_clean = clean_q;
	assign found        = found_q;
	assign found_slot   = fslot_q;
	assign entry_status = fsts_q;
	assign entry_length = flen_q;
	assign byte_out     = bout_q;

endmodule

@@ src/completion_result_ring_core.sv @@
// Top level of the completion result ring: front end, queue and back end.
// Depends on crr_pkg, crr_front and crr_back.
//
// Usage:
//   Requests enter on in_valid/in_stall with req_type and its operand fields;
//   a request is taken at a clock edge with in_valid high and in_stall low.
//   Every request produces exactly one result on out_valid/out_stall, in
//   request order. The front end holds up to two classified requests, so the
//   sender keeps going while a result waits in the output register.
//   Path from acceptance to out_valid: a request waits in the queue until the
//   back end issues it; store, payload byte, remove and unknown requests load
//   the output register at issue, and a byte read first passes S_RD_WAIT for
//   the registered payload memory read. A find walks the live entries from
//   the oldest and stops at the first match or after the newest; each entry
//   costs one header read and one compare. The single back end sequencer
//   starts a request only once it is idle and the output register is empty.
//   Reset empties the ring and the queue; stored headers and payload are
//   left as they are and count as unwritten. While out_stall is high the
//   result holds, the back end waits, and in_stall rises once the queue fills.
module completion_result_ring_core #(
	parameter int DEPTH       = crr_pkg::DEPTH_DEF,
	parameter int MAX_PAYLOAD = crr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [crr_pkg::REQ_W-1:0]      req_type,
	input  logic [crr_pkg::HANDLE_W-1:0]   handle,
	input  logic [crr_pkg::STATUS_W-1:0]   status_in,
	input  logic [crr_pkg::LEN_IN_W-1:0]   response_length,
	input  logic [crr_pkg::BYTE_W-1:0]     payload_byte,
	input  logic [crr_pkg::SLOT_W-1:0]     slot_index,
	input  logic [crr_pkg::OFF_W-1:0]      byte_offset,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           stored_clean,
	output logic                           found,
	output logic [crr_pkg::SLOT_W-1:0]     found_slot,
	output logic [crr_pkg::STATUS_W-1:0]   entry_status,
	output logic [crr_pkg::LEN_OUT_W-1:0]  entry_length,
	output logic [crr_pkg::BYTE_W-1:0]     byte_out
);
	import crr_pkg::*;

	qhead_t qhead;
	logic   pop;

	crr_front #(
		.DEPTH       (DEPTH),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.handle          (handle),
		.status_in       (status_in),
		.response_length (response_length),
		.payload_byte    (payload_byte),
		.slot_index      (slot_index),
		.byte_offset     (byte_offset),
		.pop             (pop),
		.qhead           (qhead)
	);

	crr_back #(
		.DEPTH       (DEPTH),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qhead        (qhead),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.stored_clean (stored_clean),
		.found        (found),
		.found_slot   (found_slot),
		.entry_status (entry_status),
		.entry_length (entry_length),
		.byte_out     (byte_out)
	);

endmodule

@@ src/crr_checker.sv @@
// Port-level checks for completion_result_ring_core, attached by bind.
// Depends on crr_pkg.
module crr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           stored_clean,
	input logic                           found,
	input logic [crr_pkg::SLOT_W-1:0]     found_slot,
	input logic [crr_pkg::STATUS_W-1:0]   entry_status,
	input logic [crr_pkg::LEN_OUT_W-1:0]  entry_length,
	input logic [crr_pkg::BYTE_W-1:0]     byte_out
);

	// A held result must not change while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(byte_out)
			&& $stable(stored_clean) && $stable(entry_status))
		else $error("result changed under stall");

	// Without a match, the find fields stay zero.
	a_nofind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_slot == '0 && entry_status == '0
			&& entry_length == '0)
		else $error("find fields set without a match");

	// A find result carries no store or byte result.
	a_find_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !stored_clean && byte_out == '0)
		else $error("find result mixed with other request results");

	// A clean store carries no find or byte result.
	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stored_clean |-> !found && byte_out == '0)
		else $error("store result mixed with other request results");

endmodule

bind completion_result_ring_core crr_checker u_crr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.stored_clean (stored_clean),
	.found        (found),
	.found_slot   (found_slot),
	.entry_status (entry_status),
	.entry_length (entry_length),
	.byte_out     (byte_out)
);
